// File: rtl/sst_pkg.sv
// Package for the scoped symbol table: request and status codes, sequencer
// states, the result record and the fixed field widths of the stream ports.
// No dependencies.
`default_nettype none

package sst_pkg;

    localparam int REQ_BITS     = 3;
    localparam int KEY_IN_BITS  = 32;
    localparam int DECL_IO_BITS = 16;
    localparam int IDX_BITS     = 9;
    localparam int STATUS_BITS  = 2;

    localparam int S_TDATA_BITS = 64;
    localparam int M_TDATA_BITS = 24;
    localparam int RES_BITS     = 1 + DECL_IO_BITS + STATUS_BITS;

    localparam logic [REQ_BITS-1:0] REQ_FIND    = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_INSERT  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_ENUM_IN = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_ENUM_GL = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_OPEN    = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_CLOSE   = 3'd5;

    localparam logic [STATUS_BITS-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_REJECT      = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_STORE_FULL  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_SCOPE_FULL  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_GDATA,
        S_LDATA,
        S_RESP
    } t_state;

    // hit sits in the lowest bit
    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [DECL_IO_BITS-1:0] decl;
        logic                    hit;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/scoped_symbol_table_top.sv
// Scoped symbol table: global and local entry stores, scope mark stack,
// request sequencer and registered result. Depends on sst_pkg and sst_ram.
//
//   channel   dir   fields (lowest bit first)
//   s_axis    in    tuser: req_type; tdata: name_key, decl_in, enum_index
//   m_axis    out   tdata: hit, decl_out, status
//
// Find and insert of a non-zero key scan the global store then the local
// store at one RAM read a cycle. Enumerate reads via S_MARK and S_LDATA
// or S_GDATA; open goes to S_RESP, closing an inner scope passes S_MARK.
// Reset clears the counts and depth; the stores need no clearing.
// One request is in work at a time; the next is taken while a result waits
// in the output register for m_axis_tready.
`default_nettype none

module scoped_symbol_table_top #(
    parameter int GLOBAL_ENTRIES = 256,
    parameter int LOCAL_ENTRIES  = 256,
    parameter int MAX_SCOPES     = 16,
    parameter int KEY_BITS       = 32,
    parameter int DECL_BITS      = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // name_key, decl_in, enum_index
    input  wire logic [sst_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    // req_type
    input  wire logic [sst_pkg::REQ_BITS-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // hit, decl_out, status
    output logic      [sst_pkg::M_TDATA_BITS-1:0] m_axis_tdata
);

    import sst_pkg::*;

    localparam int GAW = $clog2(GLOBAL_ENTRIES);
    localparam int LAW = $clog2(LOCAL_ENTRIES);
    localparam int GCW = $clog2(GLOBAL_ENTRIES + 1);
    localparam int LCW = $clog2(LOCAL_ENTRIES + 1);
    localparam int SAW = (MAX_SCOPES > 1) ? $clog2(MAX_SCOPES) : 1;
    localparam int SDW = $clog2(MAX_SCOPES + 1);
    localparam int SCW = (GCW > LCW) ? GCW : LCW;
    localparam int GPW = (GCW > IDX_BITS) ? GCW : IDX_BITS;
    localparam int PW  = ((LCW > IDX_BITS) ? LCW : IDX_BITS) + 1;
    localparam int EW  = KEY_BITS + DECL_BITS;

    localparam int KEY_LO  = 0;
    localparam int DECL_LO = KEY_IN_BITS;
    localparam int IDX_LO  = KEY_IN_BITS + DECL_IO_BITS;

    t_state r_state, n_state;

    logic [REQ_BITS-1:0]  r_req;
    logic [KEY_BITS-1:0]  r_key;
    logic [DECL_BITS-1:0] r_decl;
    logic [IDX_BITS-1:0]  r_idx;

    logic [GCW-1:0] r_gcount, n_gcount;
    logic [LCW-1:0] r_lcount, n_lcount;
    logic [SDW-1:0] r_depth, n_depth;

    logic [SCW-1:0] r_sidx, n_sidx;
    logic           r_inloc, n_inloc;
    logic           r_cv, n_cv;
    logic           r_cl, n_cl;

    t_result r_res, n_res;
    t_result r_out;
    logic    r_out_valid, n_out_valid;

    logic [KEY_BITS-1:0]  w_in_key;
    logic [DECL_BITS-1:0] w_in_decl;
    logic [IDX_BITS-1:0]  w_in_idx;
    logic [REQ_BITS-1:0]  w_in_req;

    logic           g_we, l_we, m_we;
    logic [GAW-1:0] g_raddr;
    logic [LAW-1:0] l_raddr;
    logic [SAW-1:0] m_raddr;
    logic [EW-1:0]  g_rdata, l_rdata, w_entry;
    logic [LCW-1:0] m_rdata;

    logic           w_acc, w_load;
    logic           w_gen_ok, w_scope_full, w_close_all;
    logic           w_giss, w_liss, w_match, w_miss, w_pos_ok;
    logic [KEY_BITS-1:0]  w_rkey;
    logic [DECL_BITS-1:0] w_rdecl;
    logic [LCW-1:0] w_base;
    logic [PW-1:0]  w_pos;

    assign w_in_req  = s_axis_tuser;
    assign w_in_key  = KEY_BITS'(s_axis_tdata[KEY_LO +: KEY_IN_BITS]);
    assign w_in_decl = DECL_BITS'(s_axis_tdata[DECL_LO +: DECL_IO_BITS]);
    assign w_in_idx  = s_axis_tdata[IDX_LO +: IDX_BITS];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == S_RESP) && (!r_out_valid || m_axis_tready);

    assign w_gen_ok     = GPW'(w_in_idx) < GPW'(r_gcount);
    assign w_scope_full = r_depth >= SDW'(MAX_SCOPES);
    assign w_close_all  = r_depth <= SDW'(1);

    assign w_giss  = SCW'(r_sidx) < SCW'(r_gcount);
    assign w_liss  = SCW'(r_sidx) < SCW'(r_lcount);
    assign w_rkey  = r_cl ? l_rdata[EW-1:DECL_BITS] : g_rdata[EW-1:DECL_BITS];
    assign w_rdecl = r_cl ? l_rdata[DECL_BITS-1:0] : g_rdata[DECL_BITS-1:0];
    assign w_match = r_cv && (w_rkey == r_key);
    assign w_miss  = !w_match && !r_cv && r_inloc && !w_liss;

    assign w_base   = (r_depth != '0) ? m_rdata : '0;
    assign w_pos    = PW'(w_base) + PW'(r_idx);
    assign w_pos_ok = w_pos < PW'(r_lcount);

    assign w_entry = {r_key, r_decl};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_in_req)
                        REQ_FIND:    n_state = S_SCAN;
                        REQ_INSERT:  n_state = (w_in_key == '0) ? S_RESP : S_SCAN;
                        REQ_ENUM_IN: n_state = S_MARK;
                        REQ_ENUM_GL: n_state = w_gen_ok ? S_GDATA : S_RESP;
                        REQ_CLOSE:   n_state = w_close_all ? S_RESP : S_MARK;
                        default:     n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_match || w_miss) begin
                    n_state = S_RESP;
                end
            end
            S_MARK: begin
                n_state = (r_req == REQ_ENUM_IN && w_pos_ok) ? S_LDATA : S_RESP;
            end
            S_GDATA, S_LDATA: n_state = S_RESP;
            S_RESP: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_gcount = r_gcount;
        n_lcount = r_lcount;
        n_depth  = r_depth;
        n_sidx   = r_sidx;
        n_inloc  = r_inloc;
        n_cv     = 1'b0;
        n_cl     = r_cl;
        n_res    = r_res;
        g_we     = 1'b0;
        l_we     = 1'b0;
        m_we     = 1'b0;
        g_raddr  = GAW'(r_sidx);
        l_raddr  = LAW'(r_sidx);
        m_raddr  = SAW'(SDW'(r_depth - 1'b1));

        unique case (r_state)
            S_IDLE: begin
                n_sidx  = '0;
                n_inloc = 1'b0;
                n_res   = '0;
                if (w_acc) begin
                    unique case (w_in_req)
                        REQ_INSERT: begin
                            if (w_in_key == '0) begin
                                n_res.status = ST_REJECT;
                            end
                        end
                        REQ_ENUM_GL: begin
                            g_raddr = GAW'(GPW'(w_in_idx));
                        end
                        REQ_OPEN: begin
                            if (w_scope_full) begin
                                n_res.status = ST_SCOPE_FULL;
                            end else begin
                                m_we    = 1'b1;
                                n_depth = SDW'(r_depth + 1'b1);
                            end
                        end
                        REQ_CLOSE: begin
                            if (w_close_all) begin
                                n_lcount = '0;
                                n_depth  = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    if (r_req == REQ_INSERT) begin
                        n_res.status = ST_REJECT;
                    end else begin
                        n_res.hit  = 1'b1;
                        n_res.decl = DECL_IO_BITS'(w_rdecl);
                    end
                end else if (w_miss) begin
                    if (r_req == REQ_INSERT) begin
                        if (r_depth != '0) begin
                            if (r_lcount >= LCW'(LOCAL_ENTRIES)) begin
                                n_res.status = ST_STORE_FULL;
                            end else begin
                                l_we     = 1'b1;
                                n_lcount = LCW'(r_lcount + 1'b1);
                            end
                        end else begin
                            if (r_gcount >= GCW'(GLOBAL_ENTRIES)) begin
                                n_res.status = ST_STORE_FULL;
                            end else begin
                                g_we     = 1'b1;
                                n_gcount = GCW'(r_gcount + 1'b1);
                            end
                        end
                    end
                end else if (!r_inloc) begin
                    if (w_giss) begin
                        n_sidx = SCW'(r_sidx + 1'b1);
                        n_cv   = 1'b1;
                        n_cl   = 1'b0;
                    end else begin
                        n_sidx  = '0;
                        n_inloc = 1'b1;
                    end
                end else if (w_liss) begin
                    n_sidx = SCW'(r_sidx + 1'b1);
                    n_cv   = 1'b1;
                    n_cl   = 1'b1;
                end
            end
            S_MARK: begin
                if (r_req == REQ_ENUM_IN) begin
                    l_raddr = LAW'(w_pos);
                end else begin
                    n_depth = SDW'(r_depth - 1'b1);
                    if (m_rdata < r_lcount) begin
                        n_lcount = m_rdata;
                    end
                end
            end
            S_GDATA: begin
                n_res.hit  = 1'b1;
                n_res.decl = DECL_IO_BITS'(g_rdata[DECL_BITS-1:0]);
            end
            S_LDATA: begin
                n_res.hit  = 1'b1;
                n_res.decl = DECL_IO_BITS'(l_rdata[DECL_BITS-1:0]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gcount    <= '0;
            r_lcount    <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_cv        <= 1'b0;
            r_inloc     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gcount    <= n_gcount;
            r_lcount    <= n_lcount;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            r_cv        <= n_cv;
            r_inloc     <= n_inloc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req  <= w_in_req;
            r_key  <= w_in_key;
            r_decl <= w_in_decl;
            r_idx  <= w_in_idx;
        end
        if (w_load) begin
            r_out <= r_res;
        end
        r_sidx <= n_sidx;
        r_cl   <= n_cl;
        r_res  <= n_res;
    end

    sst_ram #(
        .WIDTH(EW),
        .DEPTH(GLOBAL_ENTRIES),
        .AW   (GAW)
    ) u_global (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_waddr(GAW'(r_gcount)),
        .i_wdata(w_entry),
        .i_raddr(g_raddr),
        .o_rdata(g_rdata)
    );

    sst_ram #(
        .WIDTH(EW),
        .DEPTH(LOCAL_ENTRIES),
        .AW   (LAW)
    ) u_local (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(LAW'(r_lcount)),
        .i_wdata(w_entry),
        .i_raddr(l_raddr),
        .o_rdata(l_rdata)
    );

    sst_ram #(
        .WIDTH(LCW),
        .DEPTH(MAX_SCOPES),
        .AW   (SAW)
    ) u_marks (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(SAW'(r_depth)),
        .i_wdata(r_lcount),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_BITS'(r_out);

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gcount <= GCW'(GLOBAL_ENTRIES)) && (r_lcount <= LCW'(LOCAL_ENTRIES)))
        else $error("entry count beyond store depth");

    a_depth_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= SDW'(MAX_SCOPES))
        else $error("scope depth beyond stack size");

    a_no_locals_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth == '0) |-> (r_lcount == '0))
        else $error("local entries present with no open scope");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != S_IDLE))
        else $error("request accepted without work");

    a_one_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({g_we, l_we, m_we}) <= 1)
        else $error("more than one store written in a cycle");

endmodule

`default_nettype wire

// File: rtl/sst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for scoped_symbol_table_top: a directed table, then random
// traffic in three phases, with random idling on both stream sides.
// Depends on sst_pkg and the RTL of the top level only.
`timescale 1ns / 1ps

module testbench;

    import sst_pkg::*;

    localparam int G_ENTRIES = 256;
    localparam int L_ENTRIES = 256;
    localparam int N_SCOPES  = 16;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [REQ_BITS-1:0] REQ_UNUSED_7 = 3'd7;

    localparam t_result NOTHING  = '{status: ST_OK, decl: '0, hit: 1'b0};
    localparam t_result REJECTED = '{status: ST_REJECT, decl: '0, hit: 1'b0};

    typedef struct packed {
        logic [REQ_BITS-1:0]     req;
        logic [KEY_IN_BITS-1:0]  key;
        logic [DECL_IO_BITS-1:0] decl;
        logic [IDX_BITS-1:0]     idx;
        logic                    typed;
        t_result                 want;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata = '0;
    logic [REQ_BITS-1:0]     s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;

    logic [KEY_IN_BITS-1:0]  sym_gkey  [G_ENTRIES];
    logic [DECL_IO_BITS-1:0] sym_gdecl [G_ENTRIES];
    logic [KEY_IN_BITS-1:0]  sym_lkey  [L_ENTRIES];
    logic [DECL_IO_BITS-1:0] sym_ldecl [L_ENTRIES];
    int                      sym_marks [N_SCOPES];
    int                      sym_gcount = 0;
    int                      sym_lcount = 0;
    int                      sym_depth = 0;

    t_result due_replies [$];
    t_result chk_got;
    t_result chk_want;
    int      n_errors = 0;
    int      n_sent = 0;
    int      calm [2] = '{0, 0};
    bit      held = 1'b0;
    int      stall_len;

    t_dir_row dir_rows [26] = '{
        '{REQ_FIND,     32'h0000_0000, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_ENUM_GL,  32'h0000_0000, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_ENUM_IN,  32'h0000_0000, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_INSERT,   32'h0000_0000, 16'hABCD, 9'd0,   1'b1, REJECTED},
        '{REQ_INSERT,   32'hFFFF_FFFF, 16'hFFFF, 9'd0,   1'b1, NOTHING},
        '{REQ_INSERT,   32'hFFFF_FFFF, 16'h0001, 9'd0,   1'b1, REJECTED},
        '{REQ_FIND,     32'hFFFF_FFFF, 16'h0000, 9'd0,   1'b1, '{ST_OK, 16'hFFFF, 1'b1}},
        '{REQ_INSERT,   32'h0000_0001, 16'h0000, 9'd511, 1'b1, NOTHING},
        '{REQ_ENUM_GL,  32'h0000_0000, 16'h0000, 9'd1,   1'b1, '{ST_OK, 16'h0000, 1'b1}},
        '{REQ_ENUM_GL,  32'h0000_0000, 16'h0000, 9'd511, 1'b1, NOTHING},
        '{REQ_CLOSE,    32'h0000_0000, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_OPEN,     32'h0000_0000, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_INSERT,   32'h8000_0000, 16'h8000, 9'd0,   1'b1, NOTHING},
        '{REQ_FIND,     32'h8000_0000, 16'h0000, 9'd0,   1'b1, '{ST_OK, 16'h8000, 1'b1}},
        '{REQ_ENUM_IN,  32'h0000_0000, 16'h0000, 9'd0,   1'b1, '{ST_OK, 16'h8000, 1'b1}},
        '{REQ_OPEN,     32'h0000_0000, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_INSERT,   32'h5555_AAAA, 16'h1234, 9'd0,   1'b0, NOTHING},
        '{REQ_ENUM_IN,  32'h0000_0000, 16'h0000, 9'd0,   1'b0, NOTHING},
        '{REQ_ENUM_IN,  32'h0000_0000, 16'h0000, 9'd1,   1'b1, NOTHING},
        '{REQ_INSERT,   32'h8000_0000, 16'h7777, 9'd0,   1'b1, REJECTED},
        '{REQ_CLOSE,    32'h0000_0000, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_FIND,     32'h5555_AAAA, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_UNUSED_6, 32'hFFFF_FFFF, 16'hFFFF, 9'd511, 1'b1, NOTHING},
        '{REQ_UNUSED_7, 32'hAAAA_5555, 16'h5555, 9'd170, 1'b1, NOTHING},
        '{REQ_CLOSE,    32'h0000_0000, 16'h0000, 9'd0,   1'b1, NOTHING},
        '{REQ_FIND,     32'h8000_0000, 16'h0000, 9'd0,   1'b1, NOTHING}
    };

    scoped_symbol_table_top #(
        .GLOBAL_ENTRIES(G_ENTRIES),
        .LOCAL_ENTRIES (L_ENTRIES),
        .MAX_SCOPES    (N_SCOPES),
        .KEY_BITS      (KEY_IN_BITS),
        .DECL_BITS     (DECL_IO_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit symtab_lookup(input logic [KEY_IN_BITS-1:0] key,
                                         output logic [DECL_IO_BITS-1:0] decl);
        decl = '0;
        for (int i = 0; i < sym_gcount; i++) begin
            if (sym_gkey[i] == key) begin
                decl = sym_gdecl[i];
                return 1'b1;
            end
        end
        for (int i = 0; i < sym_lcount; i++) begin
            if (sym_lkey[i] == key) begin
                decl = sym_ldecl[i];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_result symtab_apply(input logic [REQ_BITS-1:0] req,
                                             input logic [KEY_IN_BITS-1:0] key,
                                             input logic [DECL_IO_BITS-1:0] din,
                                             input logic [IDX_BITS-1:0] idx);
        t_result                 r;
        logic [DECL_IO_BITS-1:0] found;
        int                      base;
        int                      mark;
        r = NOTHING;
        case (req)
            REQ_FIND: begin
                if (symtab_lookup(key, found)) begin
                    r.hit  = 1'b1;
                    r.decl = found;
                end
            end
            REQ_INSERT: begin
                if (key == '0 || symtab_lookup(key, found)) begin
                    r.status = ST_REJECT;
                end else if (sym_depth != 0) begin
                    if (sym_lcount >= L_ENTRIES) begin
                        r.status = ST_STORE_FULL;
                    end else begin
                        sym_lkey[sym_lcount]  = key;
                        sym_ldecl[sym_lcount] = din;
                        sym_lcount++;
                    end
                end else if (sym_gcount >= G_ENTRIES) begin
                    r.status = ST_STORE_FULL;
                end else begin
                    sym_gkey[sym_gcount]  = key;
                    sym_gdecl[sym_gcount] = din;
                    sym_gcount++;
                end
            end
            REQ_ENUM_IN: begin
                base = (sym_depth != 0) ? sym_marks[sym_depth-1] : 0;
                if (base + int'(idx) < sym_lcount) begin
                    r.hit  = 1'b1;
                    r.decl = sym_ldecl[base + int'(idx)];
                end
            end
            REQ_ENUM_GL: begin
                if (int'(idx) < sym_gcount) begin
                    r.hit  = 1'b1;
                    r.decl = sym_gdecl[idx];
                end
            end
            REQ_OPEN: begin
                if (sym_depth >= N_SCOPES) begin
                    r.status = ST_SCOPE_FULL;
                end else begin
                    sym_marks[sym_depth] = sym_lcount;
                    sym_depth++;
                end
            end
            REQ_CLOSE: begin
                if (sym_depth <= 1) begin
                    sym_lcount = 0;
                    sym_depth  = 0;
                end else begin
                    mark = sym_marks[sym_depth-1];
                    sym_depth--;
                    if (mark < sym_lcount) sym_lcount = mark;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch without any
    function automatic int pick_gap(input int side);
        int r;
        if (calm[side] > 0) begin
            calm[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm[side] = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_IN_BITS-1:0] pick_key(input int zero_pct, input int known_pct);
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return '0;
        if (r < zero_pct + known_pct && sym_gcount + sym_lcount > 0) begin
            k = $urandom_range(0, sym_gcount + sym_lcount - 1);
            return (k < sym_gcount) ? sym_gkey[k] : sym_lkey[k - sym_gcount];
        end
        return $urandom;
    endfunction

    function automatic logic [REQ_BITS-1:0] pick_req(input int phase);
        int                  w [7];
        logic [REQ_BITS-1:0] codes [7];
        int                  r;
        int                  acc;
        codes = '{REQ_FIND, REQ_INSERT, REQ_ENUM_IN, REQ_ENUM_GL, REQ_OPEN, REQ_CLOSE,
                  REQ_UNUSED_6};
        case (phase)
            1:       w = '{18, 60, 4, 10, 3, 4, 1};
            2:       w = '{12, 65, 8, 4, 9, 0, 2};
            default: w = '{25, 25, 15, 10, 12, 11, 2};
        endcase
        r   = $urandom_range(0, 99);
        acc = 0;
        for (int k = 0; k < 7; k++) begin
            acc += w[k];
            if (r < acc) begin
                if (codes[k] == REQ_UNUSED_6 && $urandom_range(0, 1) == 1) return REQ_UNUSED_7;
                return codes[k];
            end
        end
        return REQ_FIND;
    endfunction

    task automatic send_request(input logic [REQ_BITS-1:0] req,
                                input logic [KEY_IN_BITS-1:0] key,
                                input logic [DECL_IO_BITS-1:0] din,
                                input logic [IDX_BITS-1:0] idx,
                                input logic typed,
                                input t_result want);
        int      gap;
        t_result pred;
        gap = pick_gap(0);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'b0, idx, din, key};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = symtab_apply(req, key, din, idx);
        due_replies.insert(due_replies.size(), typed ? want : pred);
        n_sent++;
    endtask

    task automatic run_random(input int n_items, input int phase);
        logic [REQ_BITS-1:0]    req;
        logic [KEY_IN_BITS-1:0] key;
        logic [IDX_BITS-1:0]    idx;
        int                     base;
        for (int i = 0; i < n_items; i++) begin
            req = pick_req(phase);
            if (phase == 2 && req == REQ_INSERT && sym_depth == 0) req = REQ_OPEN;
            key = $urandom;
            idx = $urandom_range(0, 511);
            case (req)
                REQ_FIND:   key = pick_key(5, 60);
                REQ_INSERT: key = (phase == 3) ? pick_key(10, 30) : pick_key(4, 6);
                REQ_ENUM_GL: begin
                    if ($urandom_range(0, 9) < 7) idx = $urandom_range(0, sym_gcount);
                end
                REQ_ENUM_IN: begin
                    base = (sym_depth != 0) ? sym_marks[sym_depth-1] : 0;
                    if ($urandom_range(0, 9) < 7) idx = $urandom_range(0, sym_lcount - base + 1);
                end
                default: ;
            endcase
            send_request(req, key, $urandom, idx, 1'b0, NOTHING);
        end
    endtask

    // receiver: random stalls, plus one long hold-off so the input side backs up
    initial begin
        wait (i_rst_n);
        forever begin
            if (!held && n_sent >= 100) begin
                held      = 1'b1;
                stall_len = 1500;
            end else begin
                stall_len = pick_gap(1);
            end
            if (stall_len != 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall_len - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            chk_got = t_result'(m_axis_tdata[RES_BITS-1:0]);
            if (due_replies.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got %h",
                         $time, m_axis_tdata);
                n_errors++;
            end else begin
                chk_want = due_replies.pop_front();
                if (chk_got.hit !== chk_want.hit) begin
                    $display("%0t: hit expected %0d, got %0d", $time, chk_want.hit, chk_got.hit);
                    n_errors++;
                end
                if (chk_got.decl !== chk_want.decl) begin
                    $display("%0t: decl_out expected %h, got %h",
                             $time, chk_want.decl, chk_got.decl);
                    n_errors++;
                end
                if (chk_got.status !== chk_want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, chk_want.status, chk_got.status);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req, dir_rows[i].key, dir_rows[i].decl, dir_rows[i].idx,
                         dir_rows[i].typed, dir_rows[i].want);
        end
        run_random(520, 1);
        run_random(450, 2);
        run_random(175, 3);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
